>>> rtl/sphere_capsule_collision_top_defines.svh
// ----------------------------------------------------------------------------
// Sphere/capsule collision assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CAPSULE_COLLISION_TOP_DEFINES_SVH
`define SPHERE_CAPSULE_COLLISION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision package
// Pipeline depth and the case flags shared between the pipeline modules.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NUM_STAGES = 7;

  typedef struct packed {
    logic sel_start;
    logic sel_end;
    logic hit_start;
    logic hit_end;
  } scc_flags_t;

endpackage

>>> rtl/scc_ctrl.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision pipeline control
// Per-stage valid bits and the load-enable chain that lets bubbles collapse.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NUM_STAGES-1:0] stage_en
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stage_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

>>> rtl/scc_front.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision front end
// Stages one to three: offsets, component products, then the negated dot
// product, squared lengths and cross product magnitudes.
// ----------------------------------------------------------------------------
module scc_front import scc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic [2:0]                    stage_en,
  input  logic signed [COORD_BITS-1:0]  sphere_pos [3],
  input  logic signed [COORD_BITS-1:0]  capsule_pos [3],
  input  logic signed [COORD_BITS-1:0]  half_axis [3],
  input  logic [COORD_BITS-2:0]         sphere_radius,
  input  logic [COORD_BITS-2:0]         capsule_radius,
  output logic [2*COORD_BITS:0]         cx_mag [3],
  output logic signed [2*COORD_BITS+3:0] m_dot,
  output logic [2*COORD_BITS-1:0]       dd_len,
  output logic [2*COORD_BITS+2:0]       ww_len,
  output logic [2*COORD_BITS+2:0]       ee_len,
  output logic [2*COORD_BITS-1:0]       r2_sum
);

  localparam int CB  = COORD_BITS;
  localparam int WW  = CB + 2;
  localparam int PW  = 2 * CB + 2;
  localparam int SQX = 2 * CB + 4;
  localparam int SQ  = 2 * CB + 2;
  localparam int DW  = 2 * CB;
  localparam int CXW = 2 * CB + 3;
  localparam int CMW = 2 * CB + 1;
  localparam int MW  = 2 * CB + 4;
  localparam int LW  = 2 * CB + 3;

  logic signed [WW-1:0]  w_r [3];
  logic signed [WW-1:0]  w_nxt [3];
  logic signed [WW-1:0]  e_r [3];
  logic signed [WW-1:0]  e_nxt [3];
  logic signed [CB-1:0]  d_r [3];
  logic [CB-1:0]         rsum_r;
  logic [CB-1:0]         rsum_nxt;

  logic signed [PW-1:0]  wd_r [3][3];
  logic signed [PW-1:0]  wd_nxt [3][3];
  logic [SQ-1:0]         wsq_r [3];
  logic [SQ-1:0]         wsq_nxt [3];
  logic [SQ-1:0]         esq_r [3];
  logic [SQ-1:0]         esq_nxt [3];
  logic [DW-1:0]         dsq_r [3];
  logic [DW-1:0]         dsq_nxt [3];
  logic [DW-1:0]         r2_r;
  logic [DW-1:0]         r2_nxt;

  logic signed [CXW-1:0] cx [3];
  logic [CMW-1:0]        cmag_r [3];
  logic [CMW-1:0]        cmag_nxt [3];
  logic signed [MW-1:0]  m_r;
  logic signed [MW-1:0]  m_nxt;
  logic [DW-1:0]         dd_r;
  logic [DW-1:0]         dd_nxt;
  logic [LW-1:0]         ww_r;
  logic [LW-1:0]         ww_nxt;
  logic [LW-1:0]         ee_r;
  logic [LW-1:0]         ee_nxt;
  logic [DW-1:0]         r2s_r;

  // Stage one: offsets of the sphere centre from both segment ends.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_nxt[k] = WW'(sphere_pos[k]) - WW'(capsule_pos[k]) - WW'(half_axis[k]);
      e_nxt[k] = WW'(sphere_pos[k]) - WW'(capsule_pos[k]) + WW'(half_axis[k]);
    end
    rsum_nxt = CB'(sphere_radius) + CB'(capsule_radius);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      w_r    <= w_nxt;
      e_r    <= e_nxt;
      d_r    <= half_axis;
      rsum_r <= rsum_nxt;
    end
  end

  // Stage two: every component product needed later.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wd_nxt[i][j] = PW'(w_r[i]) * PW'(d_r[j]);
      end
      wsq_nxt[i] = SQ'(SQX'(w_r[i]) * SQX'(w_r[i]));
      esq_nxt[i] = SQ'(SQX'(e_r[i]) * SQX'(e_r[i]));
      dsq_nxt[i] = DW'(DW'(d_r[i]) * DW'(d_r[i]));
    end
    r2_nxt = DW'(rsum_r) * DW'(rsum_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      wd_r  <= wd_nxt;
      wsq_r <= wsq_nxt;
      esq_r <= esq_nxt;
      dsq_r <= dsq_nxt;
      r2_r  <= r2_nxt;
    end
  end

  // Stage three: cross product magnitudes, negated dot product and lengths.
  always_comb begin
    cx[0] = CXW'(wd_r[1][2]) - CXW'(wd_r[2][1]);
    cx[1] = CXW'(wd_r[2][0]) - CXW'(wd_r[0][2]);
    cx[2] = CXW'(wd_r[0][1]) - CXW'(wd_r[1][0]);
    for (int k = 0; k < 3; k++) begin
      cmag_nxt[k] = cx[k][CXW-1] ? CMW'(-cx[k]) : CMW'(cx[k]);
    end
    m_nxt  = -(MW'(wd_r[0][0]) + MW'(wd_r[1][1]) + MW'(wd_r[2][2]));
    dd_nxt = dsq_r[0] + dsq_r[1] + dsq_r[2];
    ww_nxt = LW'(wsq_r[0]) + LW'(wsq_r[1]) + LW'(wsq_r[2]);
    ee_nxt = LW'(esq_r[0]) + LW'(esq_r[1]) + LW'(esq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      cmag_r <= cmag_nxt;
      m_r    <= m_nxt;
      dd_r   <= dd_nxt;
      ww_r   <= ww_nxt;
      ee_r   <= ee_nxt;
      r2s_r  <= r2_r;
    end
  end

  assign cx_mag = cmag_r;
  assign m_dot  = m_r;
  assign dd_len = dd_r;
  assign ww_len = ww_r;
  assign ee_len = ee_r;
  assign r2_sum = r2s_r;

endmodule

>>> rtl/scc_back.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision back end
// Stages four to six: case flags, split wide squares and products, and the
// final sums of the interior comparison.
// ----------------------------------------------------------------------------
module scc_back import scc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic [2:0]                     stage_en,
  input  logic [2*COORD_BITS:0]          cx_mag [3],
  input  logic signed [2*COORD_BITS+3:0] m_dot,
  input  logic [2*COORD_BITS-1:0]        dd_len,
  input  logic [2*COORD_BITS+2:0]        ww_len,
  input  logic [2*COORD_BITS+2:0]        ee_len,
  input  logic [2*COORD_BITS-1:0]        r2_sum,
  output logic [4*COORD_BITS+3:0]        lhs,
  output logic [4*COORD_BITS-1:0]        rhs,
  output scc_flags_t                     flags
);

  localparam int CB  = COORD_BITS;
  localparam int CMW = 2 * CB + 1;
  localparam int LO  = CB + 1;
  localparam int HW  = CMW - LO;
  localparam int MW  = 2 * CB + 4;
  localparam int LNW = 2 * CB + 3;
  localparam int SQW = 4 * CB + 2;
  localparam int RW  = 4 * CB;
  localparam int LHW = 4 * CB + 4;

  logic signed [MW-1:0]  dd2;
  scc_flags_t            flg4_nxt;
  scc_flags_t            flg4_r;
  scc_flags_t            flg5_r;
  scc_flags_t            flg6_r;

  logic [2*HW-1:0]       phh_r [3];
  logic [2*HW-1:0]       phh_nxt [3];
  logic [HW+LO-1:0]      phl_r [3];
  logic [HW+LO-1:0]      phl_nxt [3];
  logic [2*LO-1:0]       pll_r [3];
  logic [2*LO-1:0]       pll_nxt [3];
  logic [2*CB-1:0]       rhh_r;
  logic [2*CB-1:0]       rhl_r;
  logic [2*CB-1:0]       rlh_r;
  logic [2*CB-1:0]       rll_r;
  logic [2*CB-1:0]       rhh_nxt;
  logic [2*CB-1:0]       rhl_nxt;
  logic [2*CB-1:0]       rlh_nxt;
  logic [2*CB-1:0]       rll_nxt;

  logic [SQW-1:0]        sq_r [3];
  logic [SQW-1:0]        sq_nxt [3];
  logic [RW-1:0]         rhs5_r;
  logic [RW-1:0]         rhs5_nxt;

  logic [LHW-1:0]        lhs_r;
  logic [LHW-1:0]        lhs_nxt;
  logic [RW-1:0]         rhs6_r;

  // Stage four: end-case selection and hit flags, partial products.
  always_comb begin
    dd2                = MW'({dd_len, 1'b0});
    flg4_nxt.sel_start = m_dot[MW-1] || (m_dot == '0);
    flg4_nxt.sel_end   = (m_dot >= dd2);
    flg4_nxt.hit_start = (ww_len < LNW'(r2_sum));
    flg4_nxt.hit_end   = (ee_len < LNW'(r2_sum));
    for (int k = 0; k < 3; k++) begin
      phh_nxt[k] = (2*HW)'(cx_mag[k][CMW-1:LO]) * (2*HW)'(cx_mag[k][CMW-1:LO]);
      phl_nxt[k] = (HW+LO)'(cx_mag[k][CMW-1:LO]) * (HW+LO)'(cx_mag[k][LO-1:0]);
      pll_nxt[k] = (2*LO)'(cx_mag[k][LO-1:0]) * (2*LO)'(cx_mag[k][LO-1:0]);
    end
    rhh_nxt = (2*CB)'(r2_sum[2*CB-1:CB]) * (2*CB)'(dd_len[2*CB-1:CB]);
    rhl_nxt = (2*CB)'(r2_sum[2*CB-1:CB]) * (2*CB)'(dd_len[CB-1:0]);
    rlh_nxt = (2*CB)'(r2_sum[CB-1:0]) * (2*CB)'(dd_len[2*CB-1:CB]);
    rll_nxt = (2*CB)'(r2_sum[CB-1:0]) * (2*CB)'(dd_len[CB-1:0]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      flg4_r <= flg4_nxt;
      phh_r  <= phh_nxt;
      phl_r  <= phl_nxt;
      pll_r  <= pll_nxt;
      rhh_r  <= rhh_nxt;
      rhl_r  <= rhl_nxt;
      rlh_r  <= rlh_nxt;
      rll_r  <= rll_nxt;
    end
  end

  // Stage five: reassemble each square and the right-hand product.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = (SQW'(phh_r[k]) << (2 * LO)) + (SQW'(phl_r[k]) << (LO + 1))
                + SQW'(pll_r[k]);
    end
    rhs5_nxt = (RW'(rhh_r) << (2 * CB)) + ((RW'(rhl_r) + RW'(rlh_r)) << CB)
             + RW'(rll_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      flg5_r <= flg4_r;
      sq_r   <= sq_nxt;
      rhs5_r <= rhs5_nxt;
    end
  end

  // Stage six: squared cross product length.
  assign lhs_nxt = LHW'(sq_r[0]) + LHW'(sq_r[1]) + LHW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      flg6_r <= flg5_r;
      lhs_r  <= lhs_nxt;
      rhs6_r <= rhs5_r;
    end
  end

  assign lhs   = lhs_r;
  assign rhs   = rhs6_r;
  assign flags = flg6_r;

endmodule

>>> rtl/sphere_capsule_collision_top.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision top level
// Streams sphere versus capsule overlap queries in signed Q8.8 and returns
// one hit bit per query. The datapath is a seven-stage pipeline that takes
// a new query every cycle while in_stall is low; the split wide
// multiplications of the interior test set its depth. Empty stages close up
// under output stall, so up to seven queries are held before in_stall rises.
// All arithmetic is exact: the interior case compares the squared cross
// product of the sphere offset and the half axis against the squared
// radius sum times the squared half-axis length, so no division is needed.
// ----------------------------------------------------------------------------
module sphere_capsule_collision_top import scc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_sphere_x,
  input  logic signed [COORD_BITS-1:0] in_sphere_y,
  input  logic signed [COORD_BITS-1:0] in_sphere_z,
  input  logic signed [COORD_BITS-1:0] in_capsule_x,
  input  logic signed [COORD_BITS-1:0] in_capsule_y,
  input  logic signed [COORD_BITS-1:0] in_capsule_z,
  input  logic signed [COORD_BITS-1:0] in_half_axis_x,
  input  logic signed [COORD_BITS-1:0] in_half_axis_y,
  input  logic signed [COORD_BITS-1:0] in_half_axis_z,
  input  logic [COORD_BITS-2:0]        in_sphere_radius,
  input  logic [COORD_BITS-2:0]        in_capsule_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit
);

  localparam int CB = COORD_BITS;

  logic [NUM_STAGES-1:0]    stage_en;
  logic signed [CB-1:0]     sphere_pos [3];
  logic signed [CB-1:0]     capsule_pos [3];
  logic signed [CB-1:0]     half_axis [3];
  logic [2*CB:0]            cx_mag [3];
  logic signed [2*CB+3:0]   m_dot;
  logic [2*CB-1:0]          dd_len;
  logic [2*CB+2:0]          ww_len;
  logic [2*CB+2:0]          ee_len;
  logic [2*CB-1:0]          r2_sum;
  logic [4*CB+3:0]          lhs;
  logic [4*CB-1:0]          rhs;
  scc_flags_t               flags;
  logic                     hit_nxt;
  logic                     hit_r;

  assign sphere_pos  = '{in_sphere_x, in_sphere_y, in_sphere_z};
  assign capsule_pos = '{in_capsule_x, in_capsule_y, in_capsule_z};
  assign half_axis   = '{in_half_axis_x, in_half_axis_y, in_half_axis_z};

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stage_en  (stage_en)
  );

  scc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .stage_en       (stage_en[2:0]),
    .sphere_pos     (sphere_pos),
    .capsule_pos    (capsule_pos),
    .half_axis      (half_axis),
    .sphere_radius  (in_sphere_radius),
    .capsule_radius (in_capsule_radius),
    .cx_mag         (cx_mag),
    .m_dot          (m_dot),
    .dd_len         (dd_len),
    .ww_len         (ww_len),
    .ee_len         (ee_len),
    .r2_sum         (r2_sum)
  );

  scc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .stage_en (stage_en[5:3]),
    .cx_mag   (cx_mag),
    .m_dot    (m_dot),
    .dd_len   (dd_len),
    .ww_len   (ww_len),
    .ee_len   (ee_len),
    .r2_sum   (r2_sum),
    .lhs      (lhs),
    .rhs      (rhs),
    .flags    (flags)
  );

  always_comb begin
    priority if (flags.sel_start) begin
      hit_nxt = flags.hit_start;
    end else if (flags.sel_end) begin
      hit_nxt = flags.hit_end;
    end else begin
      hit_nxt = (lhs < (4*CB+4)'(rhs));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[NUM_STAGES-1]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_hit = hit_r;

endmodule

>>> rtl/scc_checker.sv
// ----------------------------------------------------------------------------
// Sphere/capsule collision port checker
// Tracks queries in flight and checks stall and occupancy behavior.
// ----------------------------------------------------------------------------
`include "sphere_capsule_collision_top_defines.svh"

module scc_checker import scc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  localparam int OW = $clog2(NUM_STAGES + 1) + 1;

  logic          in_xfer;
  logic          out_xfer;
  logic [OW-1:0] occ_r;
  logic [OW-1:0] occ_nxt;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign occ_nxt  = occ_r + OW'(in_xfer) - OW'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `SCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hit), "stalled result changed")
  `SCC_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OW'(NUM_STAGES), "too many queries in flight")
  `SCC_ASSERT_NOW(a_empty_quiet, clk, rst_n, occ_r == '0, !out_valid, "result without a query")
  `SCC_ASSERT_NOW(a_drain_ready, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
  `SCC_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without backpressure")

endmodule

bind sphere_capsule_collision_top scc_checker u_scc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_hit   (out_hit)
);
